// ===== design/heightmap_bilinear_sampler_defines.svh =====
// Assertion macros used by the heightmap sampler checker.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH

// Property checked at every clock edge, reset included.
`define HBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while the active-low reset is released.
`define HBS_ASSERT_RUN(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

// ===== design/hbs_pkg.sv =====
// Shared constants, codes and helpers of the heightmap bilinear sampler.
`timescale 1ns / 1ps
package hbs_pkg;

    localparam int MAX_COLS_DEF  = 256;
    localparam int MAX_ROWS_DEF  = 256;
    localparam int FRAC_BITS_DEF = 8;
    localparam int QUEUE_DEPTH   = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_DATA_W-1:0] GRID_RESET = 9'd256;

    localparam int COORD_W  = 8;
    localparam int SAMPLE_W = 8;
    localparam int POS_W    = 16;

    // s_tdata layout
    localparam int COL_LSB   = 0;
    localparam int ROW_LSB   = COL_LSB + COORD_W;
    localparam int VAL_LSB   = ROW_LSB + COORD_W;
    localparam int QX_LSB    = VAL_LSB + SAMPLE_W;
    localparam int QZ_LSB    = QX_LSB + POS_W;
    localparam int S_TDATA_W = QZ_LSB + POS_W;

    localparam int M_TDATA_W = 16;
    localparam logic [M_TDATA_W-1:0] HEIGHT_MAX = '1;

    localparam int NUM_BANKS   = 4;
    localparam int BANK_SEL_W  = 2;
    localparam int OP_W        = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_OOR   = 2'd2
    } op_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== design/hbs_front.sv =====
// Front end: configuration registers, item classification and range check.
`timescale 1ns / 1ps
module hbs_front #(
    parameter int MAX_COLS  = hbs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = hbs_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = hbs_pkg::FRAC_BITS_DEF,
    localparam int COL_W    = $clog2(MAX_COLS),
    localparam int ROW_W    = $clog2(MAX_ROWS)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hbs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    output logic                            push_valid,
    input  logic                            push_ready,
    output hbs_pkg::op_t                    push_op,
    output logic [COL_W-1:0]                push_col,
    output logic [ROW_W-1:0]                push_row,
    output logic [hbs_pkg::SAMPLE_W-1:0]    push_value,
    output logic [FRAC_BITS-1:0]            push_fx,
    output logic [FRAC_BITS-1:0]            push_fz
);
    import hbs_pkg::*;

    localparam int IPOS_W = (POS_W > FRAC_BITS) ? POS_W - FRAC_BITS : 1;
    localparam int MAXD_W = $clog2(imax(MAX_COLS, MAX_ROWS) + 1);
    localparam int CMP_W  = imax(imax(MAXD_W, IPOS_W + 1), CFG_DATA_W);

    logic [CFG_DATA_W-1:0] grid_width_reg, grid_width_next;
    logic [CFG_DATA_W-1:0] grid_height_reg, grid_height_next;

    logic [COORD_W-1:0]  sample_col, sample_row;
    logic [POS_W-1:0]    query_x, query_z;
    logic [IPOS_W-1:0]   xi, zi;
    logic [CMP_W-1:0]    w_eff, h_eff;
    logic                is_query, in_store, oor;

    always_comb begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_GRID_WIDTH: begin
                    grid_width_next = cfg_wr_data;
                end
                REG_GRID_HEIGHT: begin
                    grid_height_next = cfg_wr_data;
                end
                default: begin
                    grid_width_next = grid_width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= GRID_RESET;
            grid_height_reg <= GRID_RESET;
        end else begin
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
        end
    end

    assign sample_col = s_tdata[COL_LSB +: COORD_W];
    assign sample_row = s_tdata[ROW_LSB +: COORD_W];
    assign query_x    = s_tdata[QX_LSB +: POS_W];
    assign query_z    = s_tdata[QZ_LSB +: POS_W];
    assign is_query   = s_tuser;

    assign xi = IPOS_W'(query_x >> FRAC_BITS);
    assign zi = IPOS_W'(query_z >> FRAC_BITS);

    // clamp the programmed grid size to the store
    assign w_eff = (CMP_W'(grid_width_reg) > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS)
                                                              : CMP_W'(grid_width_reg);
    assign h_eff = (CMP_W'(grid_height_reg) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS)
                                                               : CMP_W'(grid_height_reg);

    assign oor = ((CMP_W'(xi) + CMP_W'(1)) >= w_eff) || ((CMP_W'(zi) + CMP_W'(1)) >= h_eff);

    assign in_store = (CMP_W'(sample_col) < CMP_W'(MAX_COLS))
                   && (CMP_W'(sample_row) < CMP_W'(MAX_ROWS));

    // loads outside the store are accepted and dropped here
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid && push_ready && (is_query || in_store);
    assign push_op    = !is_query ? OP_LOAD : (oor ? OP_OOR : OP_QUERY);
    assign push_col   = is_query ? COL_W'(xi) : COL_W'(sample_col);
    assign push_row   = is_query ? ROW_W'(zi) : ROW_W'(sample_row);
    assign push_value = s_tdata[VAL_LSB +: SAMPLE_W];
    assign push_fx    = query_x[FRAC_BITS-1:0];
    assign push_fz    = query_z[FRAC_BITS-1:0];

endmodule

// ===== design/hbs_queue.sv =====
// Short FIFO that decouples the front end from the sample engine.
`timescale 1ns / 1ps
module hbs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hbs_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/hbs_back.sv =====
// Sample engine: four-bank height store, bilinear pipeline and output register.
`timescale 1ns / 1ps
module hbs_back #(
    parameter int MAX_COLS  = hbs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = hbs_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = hbs_pkg::FRAC_BITS_DEF,
    localparam int COL_W    = $clog2(MAX_COLS),
    localparam int ROW_W    = $clog2(MAX_ROWS)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  hbs_pkg::op_t                   q_op,
    input  logic [COL_W-1:0]               q_col,
    input  logic [ROW_W-1:0]               q_row,
    input  logic [hbs_pkg::SAMPLE_W-1:0]   q_value,
    input  logic [FRAC_BITS-1:0]           q_fx,
    input  logic [FRAC_BITS-1:0]           q_fz,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hbs_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tuser
);
    import hbs_pkg::*;

    localparam int HC_W       = (COL_W > 1) ? COL_W - 1 : 1;
    localparam int HR_W       = (ROW_W > 1) ? ROW_W - 1 : 1;
    localparam int AW         = HC_W + HR_W;
    localparam int BANK_DEPTH = 1 << AW;
    localparam int W_W        = FRAC_BITS + 1;
    localparam int A_W        = SAMPLE_W + FRAC_BITS;
    localparam int AP_W       = A_W + 1;
    localparam int SUM_W      = SAMPLE_W + 2 * FRAC_BITS;
    localparam int SP_W       = SUM_W + 1;
    localparam int RES_W      = SAMPLE_W + FRAC_BITS;
    localparam int EXT_W      = imax(RES_W, M_TDATA_W);
    localparam logic [W_W-1:0] ONE_W = {1'b1, {FRAC_BITS{1'b0}}};

    logic [SAMPLE_W-1:0] bank_mem [NUM_BANKS][BANK_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg [NUM_BANKS];
    logic [AW-1:0]       bank_addr [NUM_BANKS];
    logic [AW-1:0]       wr_addr;
    logic [BANK_SEL_W-1:0] ld_bank;
    logic [HC_W-1:0]     hc_even, hc_odd;
    logic [HR_W-1:0]     hr_even, hr_odd;
    logic                adv, issue;

    // stage 1: read data back from the banks
    logic                s1_valid_reg, s1_oor_reg, s1_c0_reg, s1_r0_reg;
    logic [FRAC_BITS-1:0] s1_fx_reg, s1_fz_reg;
    // stage 2: interpolated along x
    logic                s2_valid_reg, s2_oor_reg;
    logic [A_W-1:0]      s2_a_reg, s2_b_reg, s2_a_next, s2_b_next;
    logic [FRAC_BITS-1:0] s2_fz_reg;
    // stage 3: interpolated along z
    logic                s3_valid_reg, s3_oor_reg;
    logic [SUM_W-1:0]    s3_sum_reg, s3_sum_next;
    // output register
    logic                m_tvalid_reg, m_tuser_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [SAMPLE_W-1:0] y00, y01, y10, y11;
    logic [W_W-1:0]      wx0, wx1, wz0, wz1;
    logic [SUM_W-1:0]    rounded;
    logic [RES_W-1:0]    res_full;
    logic [EXT_W-1:0]    res_ext;

    // the whole engine moves together whenever the output slot can take an item
    assign adv     = !m_tvalid_reg || m_tready;
    assign q_ready = adv;
    assign issue   = q_valid && adv;

    // the even neighbour is col or col+1, whichever is even
    assign hc_odd  = HC_W'(q_col >> 1);
    assign hc_even = HC_W'(q_col >> 1) + HC_W'(q_col[0]);
    assign hr_odd  = HR_W'(q_row >> 1);
    assign hr_even = HR_W'(q_row >> 1) + HR_W'(q_row[0]);
    assign wr_addr = {hr_odd, hc_odd};
    assign ld_bank = {q_row[0], q_col[0]};

    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            bank_addr[b] = {(b >= 2) ? hr_odd : hr_even,
                            (b == 1 || b == 3) ? hc_odd : hc_even};
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                if (q_op == OP_LOAD && BANK_SEL_W'(b) == ld_bank) begin
                    bank_mem[b][wr_addr] <= q_value;
                end
                rd_data_reg[b] <= bank_mem[b][bank_addr[b]];
            end
        end
    end

    // route banks back to corner positions by the parity of the base cell
    assign y00 = rd_data_reg[{s1_r0_reg, s1_c0_reg}];
    assign y01 = rd_data_reg[{s1_r0_reg, ~s1_c0_reg}];
    assign y10 = rd_data_reg[{~s1_r0_reg, s1_c0_reg}];
    assign y11 = rd_data_reg[{~s1_r0_reg, ~s1_c0_reg}];

    assign wx1 = {1'b0, s1_fx_reg};
    assign wx0 = ONE_W - wx1;
    assign wz1 = {1'b0, s2_fz_reg};
    assign wz0 = ONE_W - wz1;

    assign s2_a_next = A_W'(AP_W'(y00) * AP_W'(wx0) + AP_W'(y01) * AP_W'(wx1));
    assign s2_b_next = A_W'(AP_W'(y10) * AP_W'(wx0) + AP_W'(y11) * AP_W'(wx1));

    assign s3_sum_next = SUM_W'(SP_W'(s2_a_reg) * SP_W'(wz0) + SP_W'(s2_b_reg) * SP_W'(wz1));

    // round half up, then saturate to the output width; out-of-range queries give zero
    assign rounded  = s3_sum_reg + SUM_W'(ONE_W >> 1);
    assign res_full = RES_W'(rounded >> FRAC_BITS);
    assign res_ext  = EXT_W'(res_full);

    always_comb begin
        if (s3_oor_reg) begin
            m_tdata_next = '0;
        end else if (res_ext > EXT_W'(HEIGHT_MAX)) begin
            m_tdata_next = HEIGHT_MAX;
        end else begin
            m_tdata_next = M_TDATA_W'(res_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= issue && (q_op != OP_LOAD);
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_tvalid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_oor_reg  <= (q_op == OP_OOR);
            s1_c0_reg   <= q_col[0];
            s1_r0_reg   <= q_row[0];
            s1_fx_reg   <= q_fx;
            s1_fz_reg   <= q_fz;
            s2_oor_reg  <= s1_oor_reg;
            s2_a_reg    <= s2_a_next;
            s2_b_reg    <= s2_b_next;
            s2_fz_reg   <= s1_fz_reg;
            s3_oor_reg  <= s2_oor_reg;
            s3_sum_reg  <= s3_sum_next;
            m_tuser_reg <= s3_oor_reg;
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== design/heightmap_bilinear_sampler.sv =====
// Heightmap bilinear sampler: the top level, joining front end, queue and sample engine.
// The block sustains one item per clock in both directions while the result side does not
// stall. A load item writes one height sample and yields no result; a query item yields
// one result, passing in turn through the queue, the bank read, the x-interpolation
// multiply, the z-interpolation multiply, and the rounding and output register. The store is
// split into four banks by column and row parity, so the four corners of a query come out
// of one read per bank, all in the same cycle. Samples that were never loaded read back as
// arbitrary values; there is no clearing pass after reset. Grid size registers may only be
// written while no item is in flight. The input queue holds four items, so s_tready stays
// high unless a result-side stall lasts long enough to fill the queue.
`timescale 1ns / 1ps
module heightmap_bilinear_sampler #(
    parameter int MAX_COLS  = hbs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = hbs_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = hbs_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // sample_col[7:0], sample_row[15:8], sample_value[23:16], query_x[39:24], query_z[55:40]
    input  logic [hbs_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // interp_height[15:0]
    output logic [hbs_pkg::M_TDATA_W-1:0]   m_tdata,
    // out_of_range
    output logic                            m_tuser
);
    import hbs_pkg::*;

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int FX_LSB  = 0;
    localparam int FZ_LSB  = FX_LSB + FRAC_BITS;
    localparam int V_LSB   = FZ_LSB + FRAC_BITS;
    localparam int C_LSB   = V_LSB + SAMPLE_W;
    localparam int R_LSB   = C_LSB + COL_W;
    localparam int OP_LSB  = R_LSB + ROW_W;
    localparam int ENTRY_W = OP_LSB + OP_W;

    logic                 push_valid, push_ready, pop_valid, pop_ready;
    op_t                  push_op;
    logic [COL_W-1:0]     push_col;
    logic [ROW_W-1:0]     push_row;
    logic [SAMPLE_W-1:0]  push_value;
    logic [FRAC_BITS-1:0] push_fx, push_fz;
    logic [ENTRY_W-1:0]   push_entry, pop_entry;

    hbs_front #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_op     (push_op),
        .push_col    (push_col),
        .push_row    (push_row),
        .push_value  (push_value),
        .push_fx     (push_fx),
        .push_fz     (push_fz)
    );

    assign push_entry = {push_op, push_row, push_col, push_value, push_fz, push_fx};

    hbs_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_entry)
    );

    hbs_back #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (pop_valid),
        .q_ready  (pop_ready),
        .q_op     (op_t'(pop_entry[OP_LSB +: OP_W])),
        .q_col    (pop_entry[C_LSB +: COL_W]),
        .q_row    (pop_entry[R_LSB +: ROW_W]),
        .q_value  (pop_entry[V_LSB +: SAMPLE_W]),
        .q_fx     (pop_entry[FX_LSB +: FRAC_BITS]),
        .q_fz     (pop_entry[FZ_LSB +: FRAC_BITS]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== design/hbs_checker.sv =====
// Port-level checker for the heightmap sampler, bound to the top level.
`timescale 1ns / 1ps
`include "heightmap_bilinear_sampler_defines.svh"
module hbs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [hbs_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tuser
);

    `HBS_ASSERT_ALWAYS(a_no_result_after_reset, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")

    `HBS_ASSERT_ALWAYS(a_ready_after_reset, aclk, !aresetn |=> s_tready, "input not ready after reset")

    `HBS_ASSERT_RUN(a_oor_gives_zero, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata == '0, "out-of-range result carries a nonzero height")

    `HBS_ASSERT_RUN(a_hold_on_stall, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/heightmap_bilinear_sampler_test.sv =====
// Self-checking testbench for the heightmap bilinear sampler: load/query stream with a mirror predictor.
`timescale 1ns / 1ps
module heightmap_bilinear_sampler_test;
    import hbs_pkg::*;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd2;

    localparam int GRID_COLS      = MAX_COLS_DEF;
    localparam int GRID_ROWS      = MAX_ROWS_DEF;
    localparam int FRAC           = FRAC_BITS_DEF;
    localparam int UNIT           = 1 << FRAC;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HALF_PHASE     = 125;
    localparam int TIMEOUT_CYCLES = 500000;
    localparam int NUM_PHASES     = 7;

    typedef struct {
        logic                req_type;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [SAMPLE_W-1:0] value;
        logic [POS_W-1:0]    qx;
        logic [POS_W-1:0]    qz;
    } sampler_item_t;

    typedef struct {
        logic [M_TDATA_W-1:0] height;
        logic                 oor;
    } height_result_t;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    // sample_col, sample_row, sample_value, query_x, query_z (from bit 0 up)
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    // req_type
    logic                  s_tuser     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    // interp_height
    logic [M_TDATA_W-1:0]  m_tdata;
    // out_of_range
    logic                  m_tuser;

    sampler_item_t  pending_items[$];
    height_result_t expected_heights[$];

    // predictor state: heights updated on accepted items, grid size on register writes
    logic [SAMPLE_W-1:0]   height_copy [GRID_ROWS*GRID_COLS];
    logic [CFG_DATA_W-1:0] grid_width_reg  = GRID_RESET;
    logic [CFG_DATA_W-1:0] grid_height_reg = GRID_RESET;

    // generator-side record of which samples have been loaded
    bit sample_loaded [GRID_ROWS*GRID_COLS];
    int loaded_cells[$];
    int queued_items = 0;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    int stall_left     = 0;
    int pattern_cnt    = 0;

    heightmap_bilinear_sampler i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic int eff_width();
        return (int'(grid_width_reg) > GRID_COLS) ? GRID_COLS : int'(grid_width_reg);
    endfunction

    function automatic int eff_height();
        return (int'(grid_height_reg) > GRID_ROWS) ? GRID_ROWS : int'(grid_height_reg);
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_item(input sampler_item_t it);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[COL_LSB +: COORD_W]  = it.col;
        d[ROW_LSB +: COORD_W]  = it.row;
        d[VAL_LSB +: SAMPLE_W] = it.value;
        d[QX_LSB +: POS_W]     = it.qx;
        d[QZ_LSB +: POS_W]     = it.qz;
        return d;
    endfunction

    // Apply one accepted item to the mirror; queries add their expected height.
    function automatic void interpolate_item(input sampler_item_t it);
        int xi, zi, fx, fz, base;
        longint wx0, wx1, wz0, wz1;
        longint sum, res;
        height_result_t r;
        if (it.req_type == REQ_LOAD) begin
            height_copy[{it.row, it.col}] = it.value;
            return;
        end
        xi = int'(it.qx >> FRAC);
        zi = int'(it.qz >> FRAC);
        fx = int'(it.qx) & (UNIT - 1);
        fz = int'(it.qz) & (UNIT - 1);
        if (xi + 1 >= eff_width() || zi + 1 >= eff_height()) begin
            r.height = '0;
            r.oor    = 1'b1;
        end else begin
            base = zi * GRID_COLS + xi;
            wx0  = longint'(UNIT - fx);
            wx1  = longint'(fx);
            wz0  = longint'(UNIT - fz);
            wz1  = longint'(fz);
            sum = longint'(height_copy[base]) * wx0 * wz0
                + longint'(height_copy[base + 1]) * wx1 * wz0
                + longint'(height_copy[base + GRID_COLS]) * wx0 * wz1
                + longint'(height_copy[base + GRID_COLS + 1]) * wx1 * wz1;
            res = (sum + longint'(UNIT / 2)) >>> FRAC;
            if (res > 65535) res = 65535;
            r.height = res[M_TDATA_W-1:0];
            r.oor    = 1'b0;
        end
        expected_heights.push_back(r);
    endfunction

    function automatic void push_load(input int col, input int row, input int val);
        sampler_item_t it;
        int idx;
        it.req_type = REQ_LOAD;
        it.col      = col[COORD_W-1:0];
        it.row      = row[COORD_W-1:0];
        it.value    = val[SAMPLE_W-1:0];
        it.qx       = POS_W'($urandom);
        it.qz       = POS_W'($urandom);
        idx = row * GRID_COLS + col;
        if (!sample_loaded[idx]) begin
            sample_loaded[idx] = 1'b1;
            loaded_cells.push_back(idx);
        end
        pending_items.push_back(it);
        queued_items++;
    endfunction

    // A query is safe if it is out of range or all four corners hold loaded samples.
    function automatic bit query_is_safe(input logic [POS_W-1:0] qx, input logic [POS_W-1:0] qz);
        int xi, zi, base;
        xi = int'(qx >> FRAC);
        zi = int'(qz >> FRAC);
        if (xi + 1 >= eff_width() || zi + 1 >= eff_height()) return 1'b1;
        base = zi * GRID_COLS + xi;
        return sample_loaded[base] && sample_loaded[base + 1]
            && sample_loaded[base + GRID_COLS] && sample_loaded[base + GRID_COLS + 1];
    endfunction

    function automatic void push_query(input logic [POS_W-1:0] qx, input logic [POS_W-1:0] qz);
        sampler_item_t it;
        it.req_type = REQ_QUERY;
        it.col      = COORD_W'($urandom);
        it.row      = COORD_W'($urandom);
        it.value    = SAMPLE_W'($urandom);
        it.qx       = qx;
        it.qz       = qz;
        // push the column past the grid rather than touch an unloaded sample
        if (!query_is_safe(qx, qz)) it.qx[POS_W-1:FRAC] = '1;
        pending_items.push_back(it);
        queued_items++;
    endfunction

    function automatic logic [FRAC-1:0] rand_frac();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return FRAC'(1 << (FRAC - 1));
            default: return FRAC'($urandom);
        endcase
    endfunction

    function automatic int patch_value(input int mode);
        if (mode == 0) return 255;
        if (mode == 1) return 0;
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic void push_random_query();
        logic [POS_W-1:0] qx, qz;
        int loaded_idx, w, h, xi, zi;
        w = eff_width();
        h = eff_height();
        case ($urandom_range(0, 3))
            0: begin
                qx = POS_W'($urandom);
                qz = POS_W'($urandom);
            end
            1: begin
                xi = (w >= 2) ? w - 2 + $urandom_range(0, 1) : $urandom_range(0, 255);
                zi = (h >= 2) ? h - 2 + $urandom_range(0, 1) : $urandom_range(0, 255);
                qx = {xi[7:0], rand_frac()};
                qz = {zi[7:0], rand_frac()};
            end
            default: begin
                loaded_idx = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
                qx = {loaded_idx[7:0], rand_frac()};
                qz = {loaded_idx[15:8], rand_frac()};
            end
        endcase
        push_query(qx, qz);
    endfunction

    // Load a small block of samples (inside the grid if it is 2x2 or more), then query within it.
    function automatic void push_patch();
        int span_w, span_h, dw, dh, ox, oz, mode, xi, zi;
        span_w = (eff_width() >= 2) ? eff_width() : GRID_COLS;
        span_h = (eff_height() >= 2) ? eff_height() : GRID_ROWS;
        dw = $urandom_range(2, 4);
        dh = $urandom_range(2, 4);
        if (dw > span_w) dw = span_w;
        if (dh > span_h) dh = span_h;
        ox = ($urandom_range(0, 4) == 0) ? span_w - dw : $urandom_range(0, span_w - dw);
        oz = ($urandom_range(0, 4) == 0) ? span_h - dh : $urandom_range(0, span_h - dh);
        mode = $urandom_range(0, 7);
        for (int r = 0; r < dh; r++) begin
            for (int c = 0; c < dw; c++) begin
                push_load(ox + c, oz + r, patch_value(mode));
            end
        end
        repeat ($urandom_range(2, 8)) begin
            xi = ox + $urandom_range(0, dw - 2);
            zi = oz + $urandom_range(0, dh - 2);
            push_query({xi[7:0], rand_frac()}, {zi[7:0], rand_frac()});
        end
    endfunction

    function automatic void fill_random(input int count);
        int target;
        target = queued_items + count;
        while (queued_items < target) begin
            case ($urandom_range(0, 9))
                0: push_load($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
                1, 2: push_random_query();
                default: push_patch();
            endcase
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx == REG_GRID_WIDTH) grid_width_reg = val;
        else if (idx == REG_GRID_HEIGHT) grid_height_reg = val;
    endtask

    // Hold until every item is sent and answered, then let trailing loads finish.
    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_heights.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic void note_mismatch(input string what, input int exp_v, input int act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, act_v);
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) interpolate_item(pending_items.pop_front());
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    s_tdata  <= pack_item(pending_items[0]);
                    s_tuser  <= pending_items[0].req_type;
                    s_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 5))
                            0, 1: gap_left = 0;
                            2: gap_left = $urandom_range(10, 20);
                            default: gap_left = $urandom_range(1, 6);
                        endcase
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall mode rotates through four patterns; results checked in order
    always @(posedge aclk) begin
        height_result_t exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_heights.size() == 0) begin
                    note_mismatch("unexpected result, height", -1, int'(m_tdata));
                end else begin
                    exp_r = expected_heights.pop_front();
                    if (m_tdata !== exp_r.height)
                        note_mismatch("interp_height", int'(exp_r.height), int'(m_tdata));
                    if (m_tuser !== exp_r.oor)
                        note_mismatch("out_of_range", int'(exp_r.oor), int'(m_tuser));
                end
            end
            case ((cycle_count / 300) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: begin
                    m_tready <= (pattern_cnt % 7) < 4;
                    pattern_cnt++;
                end
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                        if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("heightmap_bilinear_sampler verification failed");
            $finish;
        end
    end

    initial begin
        int widths  [NUM_PHASES];
        int heights [NUM_PHASES];
        widths  = '{2, 511, 0, 17, 0, 256, 1};
        heights = '{2, 300, 1, 9, 0, 511, 256};
        widths[4]  = $urandom_range(2, 256);
        heights[4] = $urandom_range(2, 256);

        wait (aresetn);
        repeat (2) @(posedge aclk);

        // corner samples at both grid extremes, with reset grid size
        push_load(0, 0, 0);
        push_load(1, 0, 255);
        push_load(0, 1, 255);
        push_load(1, 1, 0);
        push_query(16'h0000, 16'h0000);
        push_query(16'h0080, 16'h0080);
        push_query(16'h00FF, 16'h00FF);
        push_query(16'h0040, 16'h00C0);
        push_load(254, 254, 255);
        push_load(255, 254, 255);
        push_load(254, 255, 255);
        push_load(255, 255, 255);
        push_query(16'hFEFF, 16'hFEFF);
        push_query(16'hFE80, 16'hFE00);
        push_query(16'hFF00, 16'h0000);
        push_query(16'h0000, 16'hFF00);
        push_query(16'hFFFF, 16'hFFFF);
        // overwrite a loaded sample and read it back
        push_load(0, 0, 170);
        push_query(16'h0000, 16'h0040);
        push_query(16'h0001, 16'h0000);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(REG_GRID_WIDTH, widths[p][CFG_DATA_W-1:0]);
            write_reg(REG_GRID_HEIGHT, heights[p][CFG_DATA_W-1:0]);
            if (p == 2) write_reg(CFG_IDX_SPARE, '1);
            fill_random(HALF_PHASE);
            drain();
            fill_random(HALF_PHASE);
            drain();
        end

        if (mismatch_count == 0 && expected_heights.size() == 0) begin
            $display("heightmap_bilinear_sampler verification clean");
        end else begin
            $display("heightmap_bilinear_sampler verification failed");
        end
        $finish;
    end

endmodule
